// ===== design/cfifo_tm_pkg.sv =====
package cfifo_tm_pkg;

    // fixed field widths of a request and of the capacity register
    localparam int FUNC_W    = 2;
    localparam int SEQ_LEN_W = 7;
    localparam int SEQ_IDX_W = 6;
    localparam int CAP_W     = 7;
    localparam int STATUS_W  = 3;

    // operation codes as they arrive on func
    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_MATCH = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_MISMATCH = 3'd4
    } status_t;

    // classified request handed from the front end to the execution side
    typedef struct packed {
        op_t                  op;
        logic [SEQ_LEN_W-1:0] seq_length;
        logic [SEQ_IDX_W-1:0] seq_index;
        logic                 seq_last;
        logic                 idx_in_range;
    } cmd_t;

    // execution side sequencer
    typedef enum logic {
        BACK_IDLE,
        BACK_EXEC
    } back_state_t;

endpackage

// ===== design/cfifo_tm_front.sv =====
module cfifo_tm_front #(
    parameter int ELEM_WIDTH = 8
) (
    input  logic                             start,
    input  logic                             busy,
    input  logic [cfifo_tm_pkg::FUNC_W-1:0]    func,
    input  logic [ELEM_WIDTH-1:0]            data_in,
    input  logic [cfifo_tm_pkg::SEQ_LEN_W-1:0] seq_length,
    input  logic [cfifo_tm_pkg::SEQ_IDX_W-1:0] seq_index,
    input  logic                             seq_last,
    output logic                             push,
    output cfifo_tm_pkg::cmd_t               cmd,
    output logic [ELEM_WIDTH-1:0]            data
);
    import cfifo_tm_pkg::*;

    op_t op_dec;

    // request is taken whenever the queue has room
    assign push = start && !busy;

    // decode the operation code
    always_comb
    begin
        unique case (func)
            OP_PUSH:  op_dec = OP_PUSH;
            OP_POP:   op_dec = OP_POP;
            OP_CLEAR: op_dec = OP_CLEAR;
            default:  op_dec = OP_MATCH;
        endcase
    end

    // classify the request; the index check needs no stored state
    always_comb
    begin
        cmd.op           = op_dec;
        cmd.seq_length   = seq_length;
        cmd.seq_index    = seq_index;
        cmd.seq_last     = seq_last;
        cmd.idx_in_range = SEQ_LEN_W'(seq_index) < seq_length;
    end

    assign data = data_in;

endmodule

// ===== design/cfifo_tm_queue.sv =====
module cfifo_tm_queue #(
    parameter int ELEM_WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cfifo_tm_pkg::cmd_t    push_cmd,
    input  logic [ELEM_WIDTH-1:0] push_data,
    input  logic                  pop,
    output logic                  head_valid,
    output cfifo_tm_pkg::cmd_t    head_cmd,
    output logic [ELEM_WIDTH-1:0] head_data,
    output logic                  full
);
    import cfifo_tm_pkg::*;

    cmd_t                  cmd_slot_reg [2];
    logic [ELEM_WIDTH-1:0] data_slot_reg [2];
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            fill_reg;
    logic [1:0]            fill_next;

    assign head_valid = (fill_reg != 2'd0);
    assign full       = (fill_reg == 2'd2);
    assign head_cmd   = cmd_slot_reg[rd_ptr_reg];
    assign head_data  = data_slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_slot_reg[wr_ptr_reg]  <= push_cmd;
            data_slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/cfifo_tm_back.sv =====
module cfifo_tm_back #(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 8,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cfifo_tm_pkg::CAP_W-1:0]    cfg_data,
    input  logic                              q_valid,
    input  cfifo_tm_pkg::cmd_t                q_cmd,
    input  logic [ELEM_WIDTH-1:0]             q_data,
    output logic                              q_pop,
    output logic                              done,
    output logic [cfifo_tm_pkg::STATUS_W-1:0] status,
    output logic [ELEM_WIDTH-1:0]             data_out,
    output logic [CNT_W-1:0]                  count,
    output logic                              verdict_final
);
    import cfifo_tm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > SEQ_LEN_W) ? CNT_W : SEQ_LEN_W;
    localparam int SUM_W = CMP_W + 2;

    // element store
    logic [ELEM_WIDTH-1:0] mem [DEPTH];
    logic [ELEM_WIDTH-1:0] rd_data_reg;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic                  mem_we;

    // sequencer and latched request
    back_state_t           state_reg;
    back_state_t           state_next;
    cmd_t                  cmd_reg;
    cmd_t                  cmd_next;
    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    // buffer state
    logic [CNT_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      cap_next;
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_next;
    logic [CNT_W-1:0]      stored_reg;
    logic [CNT_W-1:0]      stored_next;
    logic                  mismatch_reg;
    logic                  mismatch_next;

    // result registers
    logic                  done_reg;
    logic                  done_next;
    status_t               status_reg;
    status_t               status_next;
    logic [ELEM_WIDTH-1:0] dout_reg;
    logic [ELEM_WIDTH-1:0] dout_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  verdict_reg;
    logic                  verdict_next;

    // helpers
    logic [CMP_W-1:0]      cfg_ext;
    logic [SUM_W-1:0]      pos_sum;
    logic [SUM_W-1:0]      pos_wrap;
    logic                  head_too_long;
    logic                  too_long;

    // step a pointer round the ring of slots in use
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] inc;
        inc = (CNT_W + 1)'(p) + 1'b1;
        return (inc >= (CNT_W + 1)'(cap)) ? '0 : PTR_W'(inc);
    endfunction

    assign done          = done_reg;
    assign status        = status_reg;
    assign data_out      = dout_reg;
    assign count         = count_reg;
    assign verdict_final = verdict_reg;

    // clamp the written capacity into 1..DEPTH
    always_comb
    begin
        cfg_ext = CMP_W'(cfg_data);
        priority if (cfg_ext == '0)
        begin
            cap_next = CNT_W'(1);
        end
        else if (cfg_ext > CMP_W'(DEPTH))
        begin
            cap_next = CNT_W'(DEPTH);
        end
        else
        begin
            cap_next = CNT_W'(cfg_ext);
        end
    end

    // slot of a tail-match element: read pointer plus offset of the tail plus index
    always_comb
    begin
        head_too_long = CMP_W'(q_cmd.seq_length) > CMP_W'(stored_reg);
        pos_sum = SUM_W'(rd_ptr_reg)
                + SUM_W'(CMP_W'(stored_reg) - CMP_W'(q_cmd.seq_length))
                + SUM_W'(q_cmd.seq_index);
        pos_wrap = (pos_sum >= SUM_W'(cap_reg)) ? pos_sum - SUM_W'(cap_reg) : pos_sum;
    end

    // next state and outputs of the sequencer
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        data_next     = data_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        stored_next   = stored_reg;
        mismatch_next = mismatch_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        dout_next     = dout_reg;
        count_next    = count_reg;
        verdict_next  = verdict_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = rd_ptr_reg;
        mem_we        = 1'b0;
        too_long      = CMP_W'(cmd_reg.seq_length) > CMP_W'(stored_reg);

        unique case (state_reg)
            BACK_IDLE:
            begin
                // take the head request and read the slot it needs
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    data_next  = q_data;
                    rd_en      = 1'b1;
                    rd_addr    = (q_cmd.op == OP_MATCH && !head_too_long)
                               ? PTR_W'(pos_wrap) : rd_ptr_reg;
                    state_next = BACK_EXEC;
                end
            end
            BACK_EXEC:
            begin
                done_next    = 1'b1;
                status_next  = ST_OK;
                dout_next    = '0;
                verdict_next = 1'b0;
                unique case (cmd_reg.op)
                    OP_PUSH:
                    begin
                        if (stored_reg >= cap_reg)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = advance(wr_ptr_reg, cap_reg);
                            stored_next = stored_reg + 1'b1;
                        end
                    end
                    OP_POP:
                    begin
                        if (stored_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            dout_next   = rd_data_reg;
                            rd_ptr_next = advance(rd_ptr_reg, cap_reg);
                            stored_next = stored_reg - 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        wr_ptr_next   = '0;
                        rd_ptr_next   = '0;
                        stored_next   = '0;
                        mismatch_next = 1'b0;
                    end
                    OP_MATCH:
                    begin
                        if (too_long)
                        begin
                            mismatch_next = 1'b1;
                        end
                        else if (cmd_reg.idx_in_range && rd_data_reg != data_reg)
                        begin
                            mismatch_next = 1'b1;
                        end
                        if (too_long)
                        begin
                            status_next = ST_TOO_LONG;
                        end
                        else if (mismatch_next)
                        begin
                            status_next = ST_MISMATCH;
                        end
                        if (cmd_reg.seq_last)
                        begin
                            verdict_next  = 1'b1;
                            mismatch_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
                count_next = stored_next;
                state_next = BACK_IDLE;
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // control and buffer state; a capacity write empties the buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BACK_IDLE;
            cap_reg      <= CNT_W'(DEPTH);
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            stored_reg   <= '0;
            mismatch_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                cap_reg      <= cap_next;
                wr_ptr_reg   <= '0;
                rd_ptr_reg   <= '0;
                stored_reg   <= '0;
                mismatch_reg <= 1'b0;
            end
            else
            begin
                wr_ptr_reg   <= wr_ptr_next;
                rd_ptr_reg   <= rd_ptr_next;
                stored_reg   <= stored_next;
                mismatch_reg <= mismatch_next;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        data_reg    <= data_next;
        status_reg  <= status_next;
        dout_reg    <= dout_next;
        count_reg   <= count_next;
        verdict_reg <= verdict_next;
    end

    // element store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= data_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // a result only follows an execute cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == BACK_EXEC))
        else $error("result strobe without an execute cycle");

    // stored count never exceeds the capacity in use
    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= cap_reg)
        else $error("stored count above capacity");

    // both pointers stay inside the ring
    a_ptr_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(wr_ptr_reg) < cap_reg) && (CNT_W'(rd_ptr_reg) < cap_reg))
        else $error("pointer outside slots in use");

    // a final verdict carries a match status only
    a_verdict_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && verdict_reg) |->
            (status_reg == ST_OK || status_reg == ST_MISMATCH ||
             status_reg == ST_TOO_LONG))
        else $error("verdict with a non-match status");

endmodule

// ===== design/circular_fifo_with_tail_match_unit.sv =====
// FIFO of ELEM_WIDTH-bit elements with a tail-match operation. A request is
// taken at a clock edge where start is high and busy is low; it lands in a
// two-entry queue, and busy is high only while that queue is full. The
// execution side handles one request at a time, in an IDLE and an EXEC state:
// the first reads the element store (registered read port), the second
// updates pointers and count and registers the result. It takes the next
// request only when through with the last, as the single element store is
// read, then updated. An accepted request passes the queue slot, the
// element-store read and the result registers. Each result is shown for
// exactly one cycle with done high; the receiver cannot stall it. Writing
// the capacity register (cfg_we, cfg_data; 0 is taken as 1, values above
// DEPTH as DEPTH) empties the buffer and must only happen while idle.
module circular_fifo_with_tail_match_unit #(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cfifo_tm_pkg::CAP_W-1:0]     cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic [cfifo_tm_pkg::FUNC_W-1:0]    func,
    input  logic [ELEM_WIDTH-1:0]              data_in,
    input  logic [cfifo_tm_pkg::SEQ_LEN_W-1:0] seq_length,
    input  logic [cfifo_tm_pkg::SEQ_IDX_W-1:0] seq_index,
    input  logic                               seq_last,
    output logic                               done,
    output logic [cfifo_tm_pkg::STATUS_W-1:0]  status,
    output logic [ELEM_WIDTH-1:0]              data_out,
    output logic [$clog2(DEPTH+1)-1:0]         count,
    output logic                               verdict_final
);
    import cfifo_tm_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                  push;
    cmd_t                  push_cmd;
    logic [ELEM_WIDTH-1:0] push_data;
    logic                  q_valid;
    cmd_t                  q_cmd;
    logic [ELEM_WIDTH-1:0] q_data;
    logic                  q_pop;
    logic                  q_full;

    assign busy = q_full;

    // accept and classify requests
    cfifo_tm_front #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .start      (start),
        .busy       (q_full),
        .func       (func),
        .data_in    (data_in),
        .seq_length (seq_length),
        .seq_index  (seq_index),
        .seq_last   (seq_last),
        .push       (push),
        .cmd        (push_cmd),
        .data       (push_data)
    );

    // decoupling queue
    cfifo_tm_queue #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_data  (push_data),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd),
        .head_data  (q_data),
        .full       (q_full)
    );

    // execution side with the element store
    cfifo_tm_back #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH),
        .CNT_W      (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .done          (done),
        .status        (status),
        .data_out      (data_out),
        .count         (count),
        .verdict_final (verdict_final)
    );

endmodule

// ===== verif/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cfifo_tm_pkg::*;

    localparam int DEPTH      = 64;
    localparam int ELEM_WIDTH = 8;
    localparam int PHASES     = 10;
    localparam int PHASE_REQS = 190;

    // one request as presented on the input ports
    typedef struct packed {
        op_t             op;
        logic [7:0]      data;
        logic [6:0]      len;
        logic [5:0]      idx;
        logic            last;
    } request_t;

    // one result as it should appear on the output ports
    typedef struct packed {
        status_t         status;
        logic [7:0]      data;
        logic [6:0]      count;
        logic            verdict;
    } outcome_t;

    // directed table entry: a capacity write or a request, optionally with a fixed result
    typedef struct packed {
        bit              is_cfg;
        bit              typed;
        logic [6:0]      cap;
        request_t        req;
        outcome_t        want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CAP_W-1:0]      cfg_data;
    logic                  start;
    logic                  busy;
    logic [FUNC_W-1:0]     func;
    logic [7:0]            data_in;
    logic [SEQ_LEN_W-1:0]  seq_length;
    logic [SEQ_IDX_W-1:0]  seq_index;
    logic                  seq_last;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [7:0]            data_out;
    logic [6:0]            count;
    logic                  verdict_final;

    // shadow copy of the fifo
    logic [7:0]  shadow_store [DEPTH];
    int          shadow_wr;
    int          shadow_rd;
    int          shadow_count;
    bit          shadow_mismatch;
    int          shadow_cap;

    outcome_t    pending_results [$];
    row_t        directed_rows [$];
    int          errors;
    int          issued;
    int          checked;
    int          cap_writes;
    int          outcome_tally [5];
    bit          steady;

    circular_fifo_with_tail_match_unit #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .data_in       (data_in),
        .seq_length    (seq_length),
        .seq_index     (seq_index),
        .seq_last      (seq_last),
        .done          (done),
        .status        (status),
        .data_out      (data_out),
        .count         (count),
        .verdict_final (verdict_final)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic void shadow_empty();
        shadow_wr       = 0;
        shadow_rd       = 0;
        shadow_count    = 0;
        shadow_mismatch = 1'b0;
    endfunction

    function automatic void shadow_set_capacity(int v);
        if (v == 0)
            shadow_cap = 1;
        else if (v > DEPTH)
            shadow_cap = DEPTH;
        else
            shadow_cap = v;
        shadow_empty();
    endfunction

    function automatic int next_slot(int p);
        return (p + 1 >= shadow_cap) ? 0 : p + 1;
    endfunction

    // element that position idx of a len-long sequence lines up with
    function automatic logic [7:0] tail_element(int len, int idx);
        return shadow_store[(shadow_rd + (shadow_count - len) + idx) % shadow_cap];
    endfunction

    // advance the shadow fifo by one request and return the result it gives
    function automatic outcome_t shadow_step(request_t r);
        outcome_t o;
        bit       too_long;
        o = '0;
        o.status = ST_OK;
        case (r.op)
            OP_PUSH:
            begin
                if (shadow_count >= shadow_cap)
                    o.status = ST_FULL;
                else
                begin
                    shadow_store[shadow_wr] = r.data;
                    shadow_wr = next_slot(shadow_wr);
                    shadow_count++;
                end
            end
            OP_POP:
            begin
                if (shadow_count == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    o.data = shadow_store[shadow_rd];
                    shadow_rd = next_slot(shadow_rd);
                    shadow_count--;
                end
            end
            OP_CLEAR:
                shadow_empty();
            default:
            begin
                too_long = int'(r.len) > shadow_count;
                if (too_long)
                    shadow_mismatch = 1'b1;
                else if (r.idx < r.len && tail_element(r.len, r.idx) != r.data)
                    shadow_mismatch = 1'b1;
                if (too_long)
                    o.status = ST_TOO_LONG;
                else if (shadow_mismatch)
                    o.status = ST_MISMATCH;
                if (r.last)
                begin
                    o.verdict = 1'b1;
                    shadow_mismatch = 1'b0;
                end
            end
        endcase
        o.count = shadow_count[6:0];
        return o;
    endfunction

    function automatic request_t make_req(op_t op, logic [7:0] d, logic [6:0] len,
                                          logic [5:0] idx, logic last);
        request_t r;
        r.op   = op;
        r.data = d;
        r.len  = len;
        r.idx  = idx;
        r.last = last;
        return r;
    endfunction

    // request with every field random apart from the operation
    function automatic request_t random_req(op_t op);
        return make_req(op, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                        6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    endfunction

    // directed table builders
    task automatic add_cfg(int v);
        row_t w;
        w = '0;
        w.is_cfg = 1'b1;
        w.cap    = 7'(v);
        directed_rows.push_back(w);
    endtask

    task automatic add_req(request_t r);
        row_t w;
        w = '0;
        w.req = r;
        directed_rows.push_back(w);
    endtask

    task automatic add_chk(request_t r, status_t st, logic [7:0] d, int cnt, bit fin);
        row_t w;
        w = '0;
        w.req          = r;
        w.typed        = 1'b1;
        w.want.status  = st;
        w.want.data    = d;
        w.want.count   = 7'(cnt);
        w.want.verdict = fin;
        directed_rows.push_back(w);
    endtask

    // present one request, hold it until taken, then queue its result
    task automatic issue(request_t r, bit typed, outcome_t fixed);
        outcome_t o;
        start      <= 1'b1;
        func       <= r.op;
        data_in    <= r.data;
        seq_length <= r.len;
        seq_index  <= r.idx;
        seq_last   <= r.last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        o = shadow_step(r);
        pending_results.push_back(typed ? fixed : o);
        issued++;
    endtask

    // random sender gaps, about one request in five
    task automatic idle_gap();
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send(request_t r);
        issue(r, 1'b0, '0);
        idle_gap();
    endtask

    // capacity write once every result is back and the pipeline has settled
    task automatic write_capacity(int v);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= 7'(v);
        @(posedge clk);
        cfg_we   <= 1'b0;
        shadow_set_capacity(v);
        cap_writes++;
    endtask

    // random traffic: bursts of pushes and pops, well-formed match runs, clears and noise
    task automatic run_phase(int quota);
        int         goal;
        int         roll;
        int         k;
        int         len;
        int         n;
        int         flip_at;
        int         cut_at;
        logic [7:0] d;
        goal = issued + quota;
        while (issued < goal)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 28)
            begin
                k = $urandom_range(1, shadow_cap + 2);
                repeat (k) send(random_req(OP_PUSH));
            end
            else if (roll < 48)
            begin
                k = $urandom_range(1, shadow_count + 2);
                repeat (k) send(random_req(OP_POP));
            end
            else if (roll < 83)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // over-long sequence, a few elements then the verdict
                    len = $urandom_range(shadow_count + 1, 127);
                    n   = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++)
                        send(make_req(OP_MATCH, 8'($urandom_range(0, 255)), 7'(len),
                                      6'(i), i == n - 1));
                end
                else
                begin
                    len     = $urandom_range(0, shadow_count);
                    flip_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : -1;
                    cut_at  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
                    if (len == 0)
                        send(make_req(OP_MATCH, 8'($urandom_range(0, 255)), 7'd0,
                                      6'($urandom_range(0, 63)), 1'b1));
                    for (int i = 0; i < len; i++)
                    begin
                        if (i == cut_at)
                            break;
                        d = tail_element(len, i);
                        if (i == flip_at)
                            d = d ^ 8'(1 << $urandom_range(0, 7));
                        send(make_req(OP_MATCH, d, 7'(len), 6'(i), i == len - 1));
                    end
                end
            end
            else if (roll < 86)
                send(random_req(OP_CLEAR));
            else
            begin
                k = $urandom_range(1, 3);
                repeat (k) send(random_req(op_t'($urandom_range(0, 3))));
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && done)
        begin
            checked++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %0d with no request outstanding", checked));
            else
            begin
                want = pending_results.pop_front();
                if (int'(want.status) <= int'(ST_MISMATCH))
                    outcome_tally[int'(want.status)]++;
                if (status !== want.status)
                    report_mismatch($sformatf("result %0d status %0h expected %0h",
                                              checked, status, want.status));
                if (data_out !== want.data)
                    report_mismatch($sformatf("result %0d data_out %0h expected %0h",
                                              checked, data_out, want.data));
                if (count !== want.count)
                    report_mismatch($sformatf("result %0d count %0d expected %0d",
                                              checked, count, want.count));
                if (verdict_final !== want.verdict)
                    report_mismatch($sformatf("result %0d verdict_final %0b expected %0b",
                                              checked, verdict_final, want.verdict));
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int cap_plan [PHASES];
        int waited;
        cap_plan   = '{64, 1, 2, 0, 5, 127, 17, 65, 33, 64};
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_data   <= '0;
        start      <= 1'b0;
        func       <= OP_PUSH;
        data_in    <= '0;
        seq_length <= '0;
        seq_index  <= '0;
        seq_last   <= 1'b0;
        errors     = 0;
        issued     = 0;
        checked    = 0;
        cap_writes = 0;
        steady     = 1'b0;
        foreach (outcome_tally[n])
            outcome_tally[n] = 0;
        shadow_cap = DEPTH;
        shadow_empty();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty buffer after reset: pop, zero-length match, over-long match
        add_chk(make_req(OP_POP, 8'h00, 7'd0, 6'd0, 1'b0), ST_EMPTY, 8'h00, 0, 1'b0);
        add_chk(make_req(OP_MATCH, 8'h00, 7'd0, 6'd0, 1'b1), ST_OK, 8'h00, 0, 1'b1);
        add_chk(make_req(OP_MATCH, 8'h00, 7'd1, 6'd0, 1'b1), ST_TOO_LONG, 8'h00, 0, 1'b1);
        add_chk(make_req(OP_PUSH, 8'h00, 7'd0, 6'd0, 1'b0), ST_OK, 8'h00, 1, 1'b0);
        add_chk(make_req(OP_PUSH, 8'hFF, 7'd0, 6'd0, 1'b0), ST_OK, 8'h00, 2, 1'b0);
        add_req(make_req(OP_PUSH, 8'hA5, 7'd0, 6'd0, 1'b0));
        // matching tail of two
        add_req(make_req(OP_MATCH, 8'hFF, 7'd2, 6'd0, 1'b0));
        add_req(make_req(OP_MATCH, 8'hA5, 7'd2, 6'd1, 1'b1));
        // sticky mismatch, then an element past the length as the verdict
        add_req(make_req(OP_MATCH, 8'h01, 7'd3, 6'd0, 1'b0));
        add_req(make_req(OP_MATCH, 8'h00, 7'd3, 6'd63, 1'b1));
        // widest length and index, sticks into a zero-length verdict
        add_req(make_req(OP_MATCH, 8'h00, 7'd127, 6'd63, 1'b0));
        add_req(make_req(OP_MATCH, 8'hFF, 7'd0, 6'd0, 1'b1));
        add_chk(make_req(OP_POP, 8'h00, 7'd0, 6'd0, 1'b0), ST_OK, 8'h00, 2, 1'b0);
        add_chk(make_req(OP_CLEAR, 8'h00, 7'd0, 6'd0, 1'b0), ST_OK, 8'h00, 0, 1'b0);
        add_chk(make_req(OP_POP, 8'h00, 7'd0, 6'd0, 1'b0), ST_EMPTY, 8'h00, 0, 1'b0);
        // zero capacity is taken as one slot
        add_cfg(0);
        add_chk(make_req(OP_PUSH, 8'h5A, 7'd0, 6'd0, 1'b0), ST_OK, 8'h00, 1, 1'b0);
        add_chk(make_req(OP_PUSH, 8'h3C, 7'd0, 6'd0, 1'b0), ST_FULL, 8'h00, 1, 1'b0);
        add_req(make_req(OP_MATCH, 8'h5A, 7'd1, 6'd0, 1'b1));
        add_chk(make_req(OP_POP, 8'h00, 7'd0, 6'd0, 1'b0), ST_OK, 8'h5A, 0, 1'b0);
        // two slots, pointers wrap
        add_cfg(2);
        add_req(make_req(OP_PUSH, 8'h11, 7'd0, 6'd0, 1'b0));
        add_req(make_req(OP_PUSH, 8'h22, 7'd0, 6'd0, 1'b0));
        add_req(make_req(OP_POP, 8'h00, 7'd0, 6'd0, 1'b0));
        add_req(make_req(OP_PUSH, 8'h33, 7'd0, 6'd0, 1'b0));
        add_req(make_req(OP_MATCH, 8'h22, 7'd2, 6'd0, 1'b0));
        add_req(make_req(OP_MATCH, 8'h33, 7'd2, 6'd1, 1'b1));

        foreach (directed_rows[n])
        begin
            if (directed_rows[n].is_cfg)
                write_capacity(directed_rows[n].cap);
            else
            begin
                issue(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);
                idle_gap();
            end
        end

        // random phases, one capacity setting each; two of them without sender gaps
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(cap_plan[p] == 33 ? $urandom_range(1, DEPTH) : cap_plan[p]);
            steady = (p == 6 || p == 7);
            run_phase(PHASE_REQS);
        end
        start <= 1'b0;

        // drain
        waited = 0;
        while (pending_results.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("run covered %0d requests, %0d results checked, %0d capacity settings",
                 issued, checked, cap_writes);
        $display("outcomes seen: ok %0d, full %0d, empty %0d, too long %0d, mismatch %0d",
                 outcome_tally[ST_OK], outcome_tally[ST_FULL], outcome_tally[ST_EMPTY],
                 outcome_tally[ST_TOO_LONG], outcome_tally[ST_MISMATCH]);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
